// File: design/flight_mode_supervisor_mixer_assert.svh
// Assertion macros for the flight mode supervisor and mixer.
`ifndef FLIGHT_MODE_SUPERVISOR_MIXER_ASSERT_SVH
`define FLIGHT_MODE_SUPERVISOR_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define FMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Condition that holds at every clock edge outside reset.
`define FMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define FMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define FMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

// File: design/fms_pkg.sv
// Shared types and constants of the flight mode supervisor and mixer.
package fms_pkg;

	localparam int TIME_BITS_DEF = 32;

	typedef enum logic [2:0] {
		K_POWER_ON  = 3'd0,
		K_POWER_OFF = 3'd1,
		K_UNLOCK    = 3'd2,
		K_LOCK      = 3'd3,
		K_LAUNCH    = 3'd4,
		K_COMMAND   = 3'd5,
		K_TICK      = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_LOCKED = 2'd1,
		MODE_SAFE   = 2'd2,
		MODE_FLIGHT = 2'd3
	} mode_t;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [2:0] REG_THROTTLE_START = 3'd0;
	localparam logic [2:0] REG_SERVO_RANGE    = 3'd1;
	localparam logic [2:0] REG_SERVO_CENTER_0 = 3'd2;
	localparam logic [2:0] REG_SERVO_CENTER_1 = 3'd3;
	localparam logic [2:0] REG_SERVO_CENTER_2 = 3'd4;
	localparam logic [2:0] REG_SERVO_CENTER_3 = 3'd5;
	localparam logic [2:0] REG_USE_CORRECTION = 3'd6;

	localparam logic [11:0] THROTTLE_START_RST = 12'd1000;
	localparam logic [11:0] SERVO_CENTER_RST   = 12'd1500;

	// Tick timing: microseconds to 1/1024 s units.
	localparam int          TICK_DIV      = 977;
	localparam logic [10:0] Q_SAT         = 11'd2047;
	localparam logic [21:0] Q_SAT_DT      = 22'(TICK_DIV * 2048);
	// ceil(2^31 / 977); exact quotient for every dividend below 2^21.
	localparam logic [21:0] DIV977_MUL    = 22'd2198039;
	localparam logic [7:0]  STEP_DT_RST   = 8'd8;
	localparam logic [7:0]  STEP_DT_MAX   = 8'd255;
	localparam logic [10:0] LOST_LIMIT    = 11'd1024;
	localparam logic [10:0] LOST_SAT      = 11'd1025;

	localparam logic [9:0]  MOTOR_MAX     = 10'd1000;
	localparam logic [9:0]  SAFE_THROTTLE = 10'd500;
	localparam logic [10:0] MIN_THROTTLE  = 11'd50;

	// Servo scaling: offset = f * range * 1000 / (45 * 2^19).
	localparam logic [17:0] RANGE_SCALE   = 18'd1000;
	// ceil(2^22 / 45); exact quotient for every dividend below 2^16.
	localparam logic [16:0] DIV45_MUL     = 17'd93207;
	localparam logic [11:0] PULSE_MAX     = 12'd4095;

	localparam logic signed [18:0] UNIT_POS = 19'sd32768;
	localparam logic signed [18:0] UNIT_NEG = -19'sd32768;
	localparam logic signed [18:0] FILT_MAX = 19'sd131072;
	localparam logic signed [18:0] FILT_MIN = -19'sd131072;

	typedef logic [3:0][18:0] filt_arr_t;
	typedef logic [3:0][11:0] pulse_arr_t;

	typedef struct packed {
		mode_t     mode;
		logic      accepted;
		logic [9:0] motor;
		filt_arr_t filt;
	} core_res_t;

endpackage

// File: design/fms_div977.sv
// Tick interval in microseconds to a clamped count of 1/1024 s units.
module fms_div977 import fms_pkg::*; #(
	parameter int DT_W = 32
) (
	input  logic [DT_W-1:0] dt,
	output logic [10:0]     q
);

	logic        over_range;
	logic [42:0] prod;

	always_comb begin
		over_range = dt >= DT_W'(Q_SAT_DT);
		prod       = 43'(dt[20:0]) * 43'(DIV977_MUL);
		// Anything past 2047 units has the same effect on the timer and step.
		q          = over_range ? Q_SAT : prod[41:31];
	end

endmodule

// File: design/fms_mix.sv
// Four-servo mixer with the eighth-step smoothing filter in Q1.17.
module fms_mix import fms_pkg::*; (
	input  logic signed [15:0] corr_x,
	input  logic signed [15:0] corr_y,
	input  logic signed [15:0] corr_z,
	input  filt_arr_t          filt_in,
	output filt_arr_t          filt_out
);

	logic signed [18:0] x2, y2, z19;
	logic signed [18:0] raw [4];
	logic signed [18:0] v [4];
	logic [18:0]        fv [4];
	logic [22:0]        s [4];

	always_comb begin
		x2  = {{2{corr_x[15]}}, corr_x, 1'b0};
		y2  = {{2{corr_y[15]}}, corr_y, 1'b0};
		z19 = {{3{corr_z[15]}}, corr_z};
		raw[0] = z19 - y2;
		raw[1] = z19 - x2;
		raw[2] = z19 + y2;
		raw[3] = z19 + x2;
		for (int k = 0; k < 4; k++) begin
			if (raw[k] > UNIT_POS) begin
				v[k] = UNIT_POS;
			end else if (raw[k] < UNIT_NEG) begin
				v[k] = UNIT_NEG;
			end else begin
				v[k] = raw[k];
			end
			fv[k] = filt_in[k];
			// (4v + 7f + 4) / 8, floored: ties round up.
			s[k] = ({{4{v[k][18]}}, v[k]} << 2) + ({{4{fv[k][18]}}, fv[k]} << 3)
				- {{4{fv[k][18]}}, fv[k]} + 23'd4;
			filt_out[k] = s[k][21:3];
		end
	end

endmodule

// File: design/fms_core.sv
// Input register, mode and timer state, and the combinational state update.
module fms_core import fms_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [31:0]        now_us,
	input  logic [15:0]        cmd_throttle,
	input  logic signed [15:0] corr_x,
	input  logic signed [15:0] corr_y,
	input  logic signed [15:0] corr_z,
	input  logic               use_correction,
	output logic               res_valid,
	input  logic               res_ready,
	output core_res_t          res
);

	localparam int DT_W = (TIME_BITS > 22) ? TIME_BITS : 22;

	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic [31:0]        now_s1;
	logic [15:0]        cmd_s1;
	logic signed [15:0] x_s1, y_s1, z_s1;
	logic               valid_s2;
	core_res_t          res_s2;

	mode_t                mode_q;
	logic [TIME_BITS-1:0] last_q;
	logic [10:0]          lost_q;
	logic [7:0]           step_q;
	logic [9:0]           motor_q;
	logic [15:0]          held_q;
	filt_arr_t            filt_q;

	logic                 ready2, adv;
	logic [63:0]          now_w;
	logic [TIME_BITS-1:0] now_t, dt;
	logic [DT_W-1:0]      dt_ext;
	logic [10:0]          q;
	logic                 started;
	logic [7:0]           step_tick;
	logic [11:0]          lost_sum;
	logic [10:0]          lost_tick;
	logic [9:0]           safe_th;

	mode_t                mode_n;
	logic [TIME_BITS-1:0] last_n;
	logic [10:0]          lost_n;
	logic [7:0]           step_n;
	logic [15:0]          held_n;
	logic                 acc_n;
	logic                 ctrl, ctrl_corr;
	logic [15:0]          th;
	logic [9:0]           motor_n;
	filt_arr_t            filt_n, mix_out;
	logic signed [15:0]   mx, my, mz;

	assign ready2    = !valid_s2 || res_ready;
	assign adv       = valid_s1 && ready2;
	assign in_ready  = !valid_s1 || ready2;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	fms_div977 #(.DT_W(DT_W)) u_div (
		.dt (dt_ext),
		.q  (q)
	);

	fms_mix u_mix (
		.corr_x   (mx),
		.corr_y   (my),
		.corr_z   (mz),
		.filt_in  (filt_q),
		.filt_out (mix_out)
	);

	always_comb begin
		now_w   = {32'd0, now_s1};
		now_t   = now_w[TIME_BITS-1:0];
		dt      = now_t - last_q;
		dt_ext  = DT_W'(dt);
		started = last_q != '0;

		if (!started) begin
			step_tick = STEP_DT_RST;
		end else if (q > 11'(STEP_DT_MAX)) begin
			step_tick = STEP_DT_MAX;
		end else if (q == '0) begin
			step_tick = 8'd1;
		end else begin
			step_tick = q[7:0];
		end

		// The timer only matters against the lost-link limit, so it saturates
		// just above it.
		lost_sum = {1'b0, lost_q} + {1'b0, q};
		if (!started) begin
			lost_tick = lost_q;
		end else if (lost_sum > 12'(LOST_SAT)) begin
			lost_tick = LOST_SAT;
		end else begin
			lost_tick = lost_sum[10:0];
		end

		if (motor_q > SAFE_THROTTLE) begin
			safe_th = SAFE_THROTTLE;
		end else if ({1'b0, motor_q} < {3'b000, step_tick} + MIN_THROTTLE) begin
			safe_th = '0;
		end else begin
			safe_th = motor_q - 10'(step_tick);
		end

		mode_n    = mode_q;
		last_n    = last_q;
		lost_n    = lost_q;
		step_n    = step_q;
		held_n    = held_q;
		acc_n     = 1'b0;
		ctrl      = 1'b0;
		ctrl_corr = 1'b0;
		th        = '0;

		case (kind_t'(kind_s1))
			K_POWER_ON: begin
				if (mode_q == MODE_OFF) begin
					mode_n = MODE_LOCKED;
					ctrl   = 1'b1;
					last_n = '0;
					acc_n  = 1'b1;
				end
			end
			K_POWER_OFF: begin
				if (mode_q != MODE_FLIGHT) begin
					mode_n = MODE_OFF;
					acc_n  = 1'b1;
				end
			end
			K_UNLOCK: begin
				if (mode_q == MODE_LOCKED) begin
					mode_n = MODE_SAFE;
					acc_n  = 1'b1;
				end
			end
			K_LOCK: begin
				if (mode_q == MODE_SAFE) begin
					mode_n = MODE_LOCKED;
					ctrl   = 1'b1;
					acc_n  = 1'b1;
				end
			end
			K_LAUNCH: begin
				if (mode_q == MODE_SAFE) begin
					mode_n = MODE_FLIGHT;
					lost_n = '0;
					acc_n  = 1'b1;
				end
			end
			K_COMMAND: begin
				held_n = cmd_s1;
				lost_n = '0;
				acc_n  = 1'b1;
			end
			K_TICK: begin
				if (mode_q != MODE_OFF) begin
					acc_n     = 1'b1;
					last_n    = now_t;
					step_n    = step_tick;
					lost_n    = lost_tick;
					ctrl_corr = use_correction;
					case (mode_q)
						MODE_FLIGHT: begin
							ctrl = 1'b1;
							if (lost_tick > LOST_LIMIT) begin
								// Lost link: drop to safe and ramp down at once.
								lost_n = '0;
								mode_n = MODE_SAFE;
								th     = 16'(safe_th);
							end else begin
								th = held_q;
							end
						end
						MODE_SAFE: begin
							ctrl = 1'b1;
							th   = 16'(safe_th);
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		mx = ctrl_corr ? x_s1 : '0;
		my = ctrl_corr ? y_s1 : '0;
		mz = ctrl_corr ? z_s1 : '0;

		if (!ctrl) begin
			motor_n = motor_q;
		end else if (th > 16'(MOTOR_MAX)) begin
			motor_n = MOTOR_MAX;
		end else begin
			motor_n = th[9:0];
		end
		filt_n = ctrl ? mix_out : filt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mode_q   <= MODE_OFF;
			last_q   <= '0;
			lost_q   <= '0;
			step_q   <= STEP_DT_RST;
			motor_q  <= '0;
			held_q   <= '0;
			filt_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				mode_q  <= mode_n;
				last_q  <= last_n;
				lost_q  <= lost_n;
				step_q  <= step_n;
				motor_q <= motor_n;
				held_q  <= held_n;
				filt_q  <= filt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			now_s1  <= now_us;
			cmd_s1  <= cmd_throttle;
			x_s1    <= corr_x;
			y_s1    <= corr_y;
			z_s1    <= corr_z;
		end
		if (adv) begin
			res_s2.mode     <= mode_n;
			res_s2.accepted <= acc_n;
			res_s2.motor    <= motor_n;
			res_s2.filt     <= filt_n;
		end
	end

endmodule

// File: design/fms_pulse.sv
// Pulse width scaling of motor and servos, and the result register.
module fms_pulse import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  core_res_t   res,
	input  logic [11:0] throttle_start,
	input  logic [17:0] range_scaled,
	input  pulse_arr_t  servo_center,
	output logic        out_valid,
	input  logic        out_ready,
	output mode_t       mode,
	output logic        accepted,
	output logic [11:0] motor_us,
	output pulse_arr_t  servo_us
);

	logic        valid_s3, valid_s4, ready3, ready4;
	mode_t       mode_s3, mode_s4;
	logic        acc_s3, acc_s4;
	logic [11:0] motor_s3, motor_s4;
	logic [3:0][15:0] mag_s3;
	logic [3:0]  neg_s3;
	pulse_arr_t  servo_s4;

	logic [12:0]        motor_sum;
	logic [11:0]        motor_sat;
	logic signed [18:0] f [4];
	logic [18:0]        fabs [4];
	logic [35:0]        prod [4];
	logic [3:0][15:0]   mag_n;
	logic [32:0]        qprod [4];
	logic [13:0]        off [4];
	logic [13:0]        p [4];
	pulse_arr_t         servo_n;

	assign ready4    = !valid_s4 || out_ready;
	assign ready3    = !valid_s3 || ready4;
	assign in_ready  = ready3;
	assign out_valid = valid_s4;
	assign mode      = mode_s4;
	assign accepted  = acc_s4;
	assign motor_us  = motor_s4;
	assign servo_us  = servo_s4;

	always_comb begin
		motor_sum = 13'(res.motor) + 13'(throttle_start);
		motor_sat = (motor_sum > 13'(PULSE_MAX)) ? PULSE_MAX : motor_sum[11:0];
		for (int k = 0; k < 4; k++) begin
			f[k]     = $signed(res.filt[k]);
			fabs[k]  = f[k][18] ? 19'(-f[k]) : 19'(f[k]);
			prod[k]  = 36'(fabs[k][17:0]) * 36'(range_scaled);
			// Divide by 2^19 here; the factor 45 is taken out in the next stage.
			mag_n[k] = prod[k][34:19];
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qprod[k] = 33'(mag_s3[k]) * 33'(DIV45_MUL);
			off[k]   = {3'b000, qprod[k][32:22]};
			// Offset rounds toward zero, so the sign goes on after division.
			p[k]     = {2'b00, servo_center[k]} + (neg_s3[k] ? 14'd0 - off[k] : off[k]);
			if (p[k][13]) begin
				servo_n[k] = '0;
			end else if (p[k] > 14'(PULSE_MAX)) begin
				servo_n[k] = PULSE_MAX;
			end else begin
				servo_n[k] = p[k][11:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready3) begin
				valid_s3 <= in_valid;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready3 && in_valid) begin
			mode_s3  <= res.mode;
			acc_s3   <= res.accepted;
			motor_s3 <= motor_sat;
			mag_s3   <= mag_n;
			for (int k = 0; k < 4; k++) begin
				neg_s3[k] <= f[k][18];
			end
		end
		if (ready4 && valid_s3) begin
			mode_s4  <= mode_s3;
			acc_s4   <= acc_s3;
			motor_s4 <= motor_s3;
			servo_s4 <= servo_n;
		end
	end

endmodule

// File: design/flight_mode_supervisor_mixer.sv
// Flight mode supervisor with lost-link timer, throttle ramp and servo mixer.
// One word is accepted per cycle unless the output stalls; the mode, timer and
// filter update for a word is settled between the input and result registers,
// and two further stages scale the pulse widths.
// Asynchronous reset: mode off, timers and filters cleared, registers at defaults.
`include "flight_mode_supervisor_mixer_assert.svh"
module flight_mode_supervisor_mixer import fms_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_us[31:0], cmd_throttle[47:32], corr_x[63:48], corr_y[79:64], corr_z[95:80]
	input  logic [95:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mode[1:0], accepted[2], motor_us[14:3], servo_0_us[26:15], servo_1_us[38:27],
	// servo_2_us[50:39], servo_3_us[62:51], zero[63]
	output logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [11:0] start_q;
	logic [7:0]  range_q;
	logic [17:0] rk_q;
	pulse_arr_t  center_q;
	logic        use_corr_q;

	logic        wr;
	logic [2:0]  reg_idx;
	logic        core_valid, core_ready;
	core_res_t   core_res;
	mode_t       out_mode;
	logic        out_acc;
	logic [11:0] out_motor;
	pulse_arr_t  out_servo;

	function automatic logic filt_ok(filt_arr_t fa);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < 4; k++) begin
			if ($signed(fa[k]) > FILT_MAX || $signed(fa[k]) < FILT_MIN) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= THROTTLE_START_RST;
			range_q    <= '0;
			rk_q       <= '0;
			center_q   <= {4{SERVO_CENTER_RST}};
			use_corr_q <= 1'b0;
		end else if (wr) begin
			case (reg_idx)
				REG_THROTTLE_START: start_q <= pwdata[11:0];
				REG_SERVO_RANGE: begin
					range_q <= pwdata[7:0];
					rk_q    <= 18'(pwdata[7:0]) * RANGE_SCALE;
				end
				REG_SERVO_CENTER_0: center_q[0] <= pwdata[11:0];
				REG_SERVO_CENTER_1: center_q[1] <= pwdata[11:0];
				REG_SERVO_CENTER_2: center_q[2] <= pwdata[11:0];
				REG_SERVO_CENTER_3: center_q[3] <= pwdata[11:0];
				REG_USE_CORRECTION: use_corr_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THROTTLE_START: prdata = 32'(start_q);
			REG_SERVO_RANGE:    prdata = 32'(range_q);
			REG_SERVO_CENTER_0: prdata = 32'(center_q[0]);
			REG_SERVO_CENTER_1: prdata = 32'(center_q[1]);
			REG_SERVO_CENTER_2: prdata = 32'(center_q[2]);
			REG_SERVO_CENTER_3: prdata = 32'(center_q[3]);
			REG_USE_CORRECTION: prdata = 32'(use_corr_q);
			default:            prdata = '0;
		endcase
	end

	fms_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.kind           (s_tuser),
		.now_us         (s_tdata[31:0]),
		.cmd_throttle   (s_tdata[47:32]),
		.corr_x         (s_tdata[63:48]),
		.corr_y         (s_tdata[79:64]),
		.corr_z         (s_tdata[95:80]),
		.use_correction (use_corr_q),
		.res_valid      (core_valid),
		.res_ready      (core_ready),
		.res            (core_res)
	);

	fms_pulse u_pulse (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (core_valid),
		.in_ready       (core_ready),
		.res            (core_res),
		.throttle_start (start_q),
		.range_scaled   (rk_q),
		.servo_center   (center_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.mode           (out_mode),
		.accepted       (out_acc),
		.motor_us       (out_motor),
		.servo_us       (out_servo)
	);

	assign m_tdata = {1'b0, out_servo, out_motor, out_acc, out_mode};

	// A free result slot must propagate back to the input in the same cycle.
	`FMS_ASSERT_IMPL(a_ready_chain, clk, arst_n, !m_tvalid || m_tready, s_tready, "input stalled with a free output slot")
	`FMS_ASSERT_IMPL(a_motor_cap, clk, arst_n, core_valid, core_res.motor <= MOTOR_MAX, "motor throttle above its cap")
	`FMS_ASSERT_IMPL(a_filt_bound, clk, arst_n, core_valid, filt_ok(core_res.filt), "servo filter outside plus or minus one")
	`FMS_ASSERT_ALWAYS(a_range_scale, clk, arst_n, rk_q == 18'(range_q) * RANGE_SCALE, "scaled servo range out of step with its register")

endmodule
